### design/lrls_pkg.sv
// shared constants, codes and state type for the lsd radix list sort core
// no dependencies; lrls_digit and the top level import this package
package lrls_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 32;
  localparam int MAX_DB      = 4;
  localparam int PILES       = 1 << MAX_DB;
  localparam int PILE_W      = MAX_DB;
  // up to fifteen passes of four bits reach past the key, so the shift needs six bits
  localparam int SHIFT_W     = 6;
  localparam int DB_W        = 3;
  localparam int NP_W        = 4;
  localparam int PASS_W      = 4;
  localparam int CFG_W       = 4;

  // register indexes
  localparam logic CFG_DIGIT_BITS   = 1'b0;
  localparam logic CFG_DIGIT_PASSES = 1'b1;

  // operation codes
  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_PULL = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_WALK,
    S_WEAVE,
    S_TAIL,
    S_PULL_RD,
    S_PULL_OUT
  } state_t;

endpackage

### design/lrls_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module lrls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lrls_digit.sv
// shared shift and mask unit: picks the radix digit of a key for the current pass
// depends on lrls_pkg
module lrls_digit (
  input  logic [lrls_pkg::KEY_W-1:0]   key,
  input  logic [lrls_pkg::SHIFT_W-1:0] shift,
  input  logic [lrls_pkg::PILE_W-1:0]  mask,
  output logic [lrls_pkg::PILE_W-1:0]  digit
);
  import lrls_pkg::*;

  logic [KEY_W-1:0] shifted;

  always_comb begin
    shifted = key >> shift;
    digit   = shifted[PILE_W-1:0] & mask;
  end

endmodule

### design/lsd_radix_list_sort_core.sv
// top level of the lsd radix list sort core: sequencer, pile table and record stores
// depends on lrls_pkg, lrls_ram and lrls_digit
//
// Usage: a command is taken when start is high and busy is low. func selects a
// load (key stored as the next record) or a pull (next record in sorted order).
// Every command gives exactly one result, shown for one cycle with done high:
// sorted_key, load_index, last and status. The receiver cannot hold results off.
// A load, a pull into an empty or exhausted store and a full-store load answer
// in the cycle after the transfer and leave busy low, so such commands may
// follow back to back. A pull on a sorted list reads the key and link stores
// in S_PULL_RD, then gives the result from S_PULL_OUT. The first pull after
// loads runs the sort: per pass S_PASS primes the read, S_WALK visits the
// records in turn through the single read port of the key and link stores and
// the shared digit unit, S_WEAVE links the piles in order and S_TAIL closes the
// list; the pull then goes on as on a sorted list. Configuration writes
// through cfg_write/cfg_index/cfg_data take effect at the next sort.
// Synchronous reset empties the store and restores 4 digit bits, 3 passes;
// the record stores themselves are not cleared.
module lsd_radix_list_sort_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [lrls_pkg::KEY_W-1:0]  key,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [lrls_pkg::CFG_W-1:0]  cfg_data,
  output logic                        done,
  output logic [lrls_pkg::KEY_W-1:0]  sorted_key,
  output logic [lrls_pkg::IDX_W-1:0]  load_index,
  output logic                        last,
  output logic [1:0]                  status
);
  import lrls_pkg::*;

  state_t state, state_next;

  logic [DB_W-1:0]    digit_bits;
  logic [NP_W-1:0]    digit_passes;
  logic [CNT_W-1:0]   record_count;
  logic [CNT_W-1:0]   emitted_count;
  logic [IDX_W-1:0]   list_head;
  logic [IDX_W-1:0]   read_cursor;
  logic               sorted_flag;
  logic [DB_W-1:0]    db;
  logic [NP_W-1:0]    np;
  logic [PILE_W-1:0]  mask;
  logic [PASS_W-1:0]  pass;
  logic [SHIFT_W-1:0] shift;
  logic [IDX_W-1:0]   cur;
  logic [CNT_W-1:0]   remaining;
  logic [PILE_W-1:0]  weave_idx;
  logic               started;
  logic [IDX_W-1:0]   prev_top;
  logic [PILES-1:0]   pile_nonempty;
  logic [IDX_W-1:0]   pile_top    [PILES];
  logic [IDX_W-1:0]   pile_bottom [PILES];

  logic               accept;
  logic               store_full;
  logic               list_empty;
  logic [DB_W-1:0]    db_clamp;
  logic [NP_W-1:0]    np_clamp;
  logic [CNT_W-1:0]   count_less1;
  logic [IDX_W-1:0]   next_idx;
  logic               last_pass;

  logic               key_we;
  logic [IDX_W-1:0]   rd_addr;
  logic               link_we;
  logic [IDX_W-1:0]   link_waddr;
  logic [IDX_W-1:0]   link_wdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [IDX_W-1:0]   link_rdata;
  logic [PILE_W-1:0]  digit;

  lrls_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RECORDS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (record_count[IDX_W-1:0]),
    .wdata (key),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  lrls_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECORDS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  lrls_digit u_digit (
    .key   (key_rdata),
    .shift (shift),
    .mask  (mask),
    .digit (digit)
  );

  always_comb begin
    busy        = (state != S_IDLE);
    accept      = start && !busy;
    store_full  = (record_count == CNT_W'(MAX_RECORDS));
    list_empty  = (record_count == '0) || (sorted_flag && (emitted_count >= record_count));
    count_less1 = record_count - CNT_W'(1);
    last_pass   = (pass == (np - NP_W'(1)));
    if (digit_bits == '0) begin
      db_clamp = DB_W'(1);
    end else if (digit_bits > DB_W'(MAX_DB)) begin
      db_clamp = DB_W'(MAX_DB);
    end else begin
      db_clamp = digit_bits;
    end
    np_clamp = (digit_passes == '0) ? NP_W'(1) : digit_passes;
    // first pass walks load positions downward, later passes follow the links
    next_idx = (pass == '0) ? (cur - IDX_W'(1)) : link_rdata;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && func == FN_PULL && !list_empty) begin
          state_next = sorted_flag ? S_PULL_RD : S_PASS;
        end
      end
      S_PASS:     state_next = S_WALK;
      S_WALK:     if (remaining == CNT_W'(1)) state_next = S_WEAVE;
      S_WEAVE:    if (weave_idx == mask) state_next = S_TAIL;
      S_TAIL:     state_next = last_pass ? S_PULL_RD : S_PASS;
      S_PULL_RD:  state_next = S_PULL_OUT;
      S_PULL_OUT: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // store controls
  always_comb begin
    key_we     = 1'b0;
    rd_addr    = read_cursor;
    link_we    = 1'b0;
    link_waddr = prev_top;
    link_wdata = prev_top;
    case (state)
      S_IDLE: begin
        key_we = accept && func == FN_LOAD && !store_full;
      end
      S_PASS: begin
        rd_addr = (pass == '0) ? count_less1[IDX_W-1:0] : list_head;
      end
      S_WALK: begin
        rd_addr    = next_idx;
        link_we    = pile_nonempty[digit];
        link_waddr = pile_top[digit];
        link_wdata = cur;
      end
      S_WEAVE: begin
        link_we    = pile_nonempty[weave_idx] && started;
        link_wdata = pile_bottom[weave_idx];
      end
      S_TAIL: begin
        // final record links to itself
        link_we = 1'b1;
      end
      default: begin
        rd_addr = read_cursor;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      digit_bits    <= DB_W'(4);
      digit_passes  <= NP_W'(3);
      record_count  <= '0;
      emitted_count <= '0;
      list_head     <= '0;
      read_cursor   <= '0;
      sorted_flag   <= 1'b0;
      pile_nonempty <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          CFG_DIGIT_BITS:   digit_bits   <= cfg_data[DB_W-1:0];
          CFG_DIGIT_PASSES: digit_passes <= cfg_data[NP_W-1:0];
          default:          digit_bits   <= digit_bits;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sorted_key <= '0;
            load_index <= '0;
            last       <= 1'b0;
            status     <= STAT_OK;
            if (func == FN_LOAD) begin
              done <= 1'b1;
              if (store_full) begin
                status <= STAT_FULL;
              end else begin
                load_index    <= record_count[IDX_W-1:0];
                record_count  <= record_count + CNT_W'(1);
                sorted_flag   <= 1'b0;
                emitted_count <= '0;
              end
            end else if (list_empty) begin
              done   <= 1'b1;
              status <= STAT_EMPTY;
            end else if (!sorted_flag) begin
              db    <= db_clamp;
              np    <= np_clamp;
              mask  <= PILE_W'((5'd1 << db_clamp) - 5'd1);
              pass  <= '0;
              shift <= '0;
            end
          end
        end
        S_PASS: begin
          pile_nonempty <= '0;
          cur           <= rd_addr;
          remaining     <= record_count;
        end
        S_WALK: begin
          if (!pile_nonempty[digit]) begin
            pile_nonempty[digit] <= 1'b1;
            pile_bottom[digit]   <= cur;
          end
          pile_top[digit] <= cur;
          cur             <= next_idx;
          remaining       <= remaining - CNT_W'(1);
          weave_idx       <= '0;
          started         <= 1'b0;
        end
        S_WEAVE: begin
          if (pile_nonempty[weave_idx]) begin
            if (!started) begin
              list_head <= pile_bottom[weave_idx];
              started   <= 1'b1;
            end
            prev_top <= pile_top[weave_idx];
          end
          weave_idx <= weave_idx + PILE_W'(1);
        end
        S_TAIL: begin
          if (last_pass) begin
            sorted_flag   <= 1'b1;
            read_cursor   <= list_head;
            emitted_count <= '0;
          end else begin
            pass  <= pass + PASS_W'(1);
            shift <= shift + SHIFT_W'(db);
          end
        end
        S_PULL_OUT: begin
          done          <= 1'b1;
          sorted_key    <= key_rdata;
          load_index    <= read_cursor;
          last          <= (emitted_count + CNT_W'(1) == record_count);
          status        <= STAT_OK;
          read_cursor   <= link_rdata;
          emitted_count <= emitted_count + CNT_W'(1);
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond store depth");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emitted_count <= record_count)
    else $error("more records emitted than loaded");

  a_pull_result: assert property (@(posedge clk) disable iff (rst)
    state == S_PULL_OUT |=> done && status == STAT_OK)
    else $error("sorted pull gave no result");

  a_unsort_on_load: assert property (@(posedge clk) disable iff (rst)
    $fell(sorted_flag) |-> $past(accept && func == FN_LOAD))
    else $error("sorted list dropped without a load");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> remaining != '0)
    else $error("walk with no records left");

endmodule
